// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the key-value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LKVC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lkvc assertion failed");
`define LKVC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("lkvc forbidden condition seen");
`else
`define LKVC_ASSERT(lbl, clk, rstn, prop)
`define LKVC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/core/lkvc_pkg.sv =====
// Types and constants shared by the key-value cache modules.
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned CapW          = 5;
  localparam logic [CapW-1:0] CapReset  = 5'd16;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned ValW          = 32;
  localparam logic [ValW-1:0] MissValue = '1;

  localparam logic OpGet = 1'b0;
  localparam logic OpSet = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic signed [ValW-1:0] read_value;
  } rsp_t;

  // Contents one cell hands to its older neighbor.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } link_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic            exec;
    logic            is_set;
    logic            hit_any;
    logic            evict;
    logic [KeyW-1:0] key;
  } bcast_t;

endpackage

// ===== rtl/core/lkvc_cell.sv =====
// One entry of the recency-ordered chain: key, value and valid bit.
`timescale 1ns / 1ps
module lkvc_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lkvc_pkg::bcast_t                     op_i,
  input  lkvc_pkg::link_t                      newer_i,
  input  logic                                 hit_older_i,
  input  logic [lkvc_pkg::ValW-1:0]            rdata_older_i,
  output lkvc_pkg::link_t                      entry_o,
  output logic                                 hit_o,
  output logic [lkvc_pkg::ValW-1:0]            rdata_o
);

  logic                        valid_q;
  logic [lkvc_pkg::KeyW-1:0]   key_q;
  logic [lkvc_pkg::ValW-1:0]   value_q;
  logic                        match;
  logic                        shift;

  assign match   = valid_q && (key_q == op_i.key);
  assign hit_o   = hit_older_i | match;
  assign rdata_o = rdata_older_i | (match ? value_q : '0);

  // On an update the entries from the front down to the hit move back by one.
  // On an insert every valid entry moves back unless it is the one evicted.
  always_comb begin
    if (op_i.hit_any) begin
      shift = hit_o;
    end else begin
      shift = newer_i.valid && (valid_q || !op_i.evict);
    end
    shift = shift && op_i.exec && op_i.is_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= newer_i.key;
      value_q <= newer_i.value;
    end
  end

  assign entry_o = '{valid: valid_q, key: key_q, value: value_q};

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// Top level of the fully associative key-value cache with LRU replacement.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------
//  in       | input     | in_valid_i/in_stall_o | in_data_i  (req_t)
//  out      | output    | out_valid_o/out_stall_i | out_data_o (rsp_t)
//  cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (capacity)
//
// The transfer registers each request, and in its execute cycle every cell
// compares its key, the hit and read data ripple through the chain, and the
// cells shift in one step. The chain of cells sets the pace.
// Reset clears all valid bits and the occupancy at once; no clearing pass.
// A get waits in its execute cycle while the result register is full and
// stalled; a new request is taken while a finished result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_key_value_cache_unit #(
  parameter int unsigned MaxEntries = lkvc_pkg::MaxEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lkvc_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lkvc_pkg::rsp_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lkvc_pkg::CapW-1:0]     cfg_data_i
);

  localparam int unsigned OccW = $clog2(MaxEntries + 1);
  localparam int unsigned EW   = (OccW > lkvc_pkg::CapW) ? OccW : lkvc_pkg::CapW;
  localparam logic [EW-1:0] MaxExt = EW'(MaxEntries);

  logic [lkvc_pkg::CapW-1:0] cap_q;
  logic [OccW-1:0]           occ_q;
  logic                      busy_q;
  lkvc_pkg::req_t            req_q;
  logic                      out_valid_q;
  lkvc_pkg::rsp_t            out_q;

  logic [EW-1:0]             eff_cap;
  logic [EW-1:0]             cap_ext;
  logic                      evict;
  logic                      exec;
  logic                      is_get;
  lkvc_pkg::bcast_t          op;

  lkvc_pkg::link_t           link [MaxEntries+1];
  logic                      hitc [MaxEntries+1];
  logic [lkvc_pkg::ValW-1:0] rdc  [MaxEntries+1];
  logic [MaxEntries-1:0]     valid_vec;

  // The configuration register can always be written.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // A capacity of zero behaves as one, and anything above the chain length
  // behaves as the chain length.
  assign cap_ext = EW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > MaxExt) begin
      eff_cap = MaxExt;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = EW'(occ_q) >= eff_cap;

  // Requests are accepted only between executions.
  assign in_stall_o = busy_q;
  assign is_get     = (req_q.opcode == lkvc_pkg::OpGet);
  assign exec       = busy_q && (!is_get || !out_valid_q || !out_stall_i);

  assign op = '{exec: exec, is_set: !is_get, hit_any: hitc[0], evict: evict,
                key: req_q.key};

  // The newest position is fed from the request itself.
  assign link[0]          = '{valid: 1'b1, key: req_q.key, value: req_q.value};
  assign hitc[MaxEntries] = 1'b0;
  assign rdc[MaxEntries]  = '0;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .newer_i       (link[i]),
      .hit_older_i   (hitc[i+1]),
      .rdata_older_i (rdc[i+1]),
      .entry_o       (link[i+1]),
      .hit_o         (hitc[i]),
      .rdata_o       (rdc[i])
    );
    assign valid_vec[i] = link[i+1].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      // Only an insert without eviction grows the occupancy.
      if (exec && !is_get && !hitc[0] && !evict) begin
        occ_q <= occ_q + OccW'(1);
      end
      if (exec && is_get) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
    if (exec && is_get) begin
      out_q.hit        <= hitc[0];
      out_q.read_value <= hitc[0] ? rdc[0] : lkvc_pkg::MissValue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid entries always match the occupancy count.
  `LKVC_ASSERT(a_occ_count, clk_i, rst_ni, $countones(valid_vec) == occ_q)
  // Occupancy never goes past the chain length.
  `LKVC_NEVER(a_occ_max, clk_i, rst_ni, EW'(occ_q) > MaxExt)
  // An executed get always leaves a result waiting.
  `LKVC_ASSERT(a_get_result, clk_i, rst_ni, (exec && is_get) |=> out_valid_q)
  // An accepted request is executed in a later cycle, never dropped.
  `LKVC_ASSERT(a_accept_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> busy_q)

endmodule
